FILE: rtl/core/udfu_pkg.sv
package udfu_pkg;

  // Largest block the device buffers.
  localparam int unsigned TRANSFER_SIZE = 1024;
  localparam logic [16:0] XferLimit     = 17'(TRANSFER_SIZE);

  // Request kinds.
  localparam logic [1:0] OP_DNLOAD    = 2'd0;
  localparam logic [1:0] OP_GETSTATUS = 2'd1;
  localparam logic [1:0] OP_CLRSTATUS = 2'd2;
  localparam logic [1:0] OP_ABORT     = 2'd3;

  // Protocol state codes.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DN_SYNC  = 3'd1;
  localparam logic [2:0] ST_DN_BUSY  = 3'd2;
  localparam logic [2:0] ST_DN_IDLE  = 3'd3;
  localparam logic [2:0] ST_MAN_SYNC = 3'd4;
  localparam logic [2:0] ST_MAN      = 3'd5;
  localparam logic [2:0] ST_ERROR    = 3'd6;

  // Protocol status codes.
  localparam logic [1:0] SC_OK      = 2'd0;
  localparam logic [1:0] SC_ADDRESS = 2'd1;
  localparam logic [1:0] SC_STALLED = 2'd2;
  localparam logic [1:0] SC_UNKNOWN = 2'd3;

  localparam logic [23:0] POLL_TIMEOUT_RESET = 24'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] block_length;
    logic [15:0] packet_offset;
    logic [6:0]  packet_length;
    logic        flash_busy;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  status_code;
    logic [2:0]  state_code;
    logic [23:0] reported_timeout;
  } rsp_t;

  // Protocol context carried from one request to the next.
  typedef struct packed {
    logic [2:0] state;
    logic [1:0] status;
  } ctx_t;

endpackage

FILE: rtl/core/udfu_if.sv
interface udfu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] block_length;
  logic [15:0] packet_offset;
  logic [6:0]  packet_length;
  logic        flash_busy;

  modport source (output valid, op, block_length, packet_offset, packet_length, flash_busy,
                  input ready);
  modport sink   (input valid, op, block_length, packet_offset, packet_length, flash_busy,
                  output ready);
endinterface

interface udfu_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [1:0]  status_code;
  logic [2:0]  state_code;
  logic [23:0] reported_timeout;

  modport source (output valid, accepted, status_code, state_code, reported_timeout,
                  input ready);
  modport sink   (input valid, accepted, status_code, state_code, reported_timeout,
                  output ready);
endinterface

interface udfu_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/udfu_step.sv
module udfu_step (
  input  udfu_pkg::ctx_t  ctx_i,
  input  udfu_pkg::req_t  req_i,
  input  logic [23:0]     poll_timeout_i,
  output udfu_pkg::ctx_t  ctx_o,
  output udfu_pkg::rsp_t  rsp_o
);

  logic [16:0] pkt_end;
  logic        ok;
  logic [23:0] tmo;

  // The packet end is one bit wider than the operands so it cannot wrap.
  assign pkt_end = {1'b0, req_i.packet_offset} + {10'd0, req_i.packet_length};

  always_comb begin
    ctx_o = ctx_i;
    ok    = 1'b1;
    tmo   = '0;
    unique case (req_i.op)
      udfu_pkg::OP_DNLOAD: begin
        if (pkt_end > udfu_pkg::XferLimit || pkt_end > {1'b0, req_i.block_length}) begin
          ctx_o = '{state: udfu_pkg::ST_ERROR, status: udfu_pkg::SC_ADDRESS};
          ok    = 1'b0;
        end else if (pkt_end == {1'b0, req_i.block_length}) begin
          if (ctx_i.state != udfu_pkg::ST_IDLE && ctx_i.state != udfu_pkg::ST_DN_IDLE) begin
            ctx_o = '{state: udfu_pkg::ST_ERROR, status: udfu_pkg::SC_STALLED};
            ok    = 1'b0;
          end else if (req_i.flash_busy) begin
            ctx_o = '{state: udfu_pkg::ST_ERROR, status: udfu_pkg::SC_UNKNOWN};
            ok    = 1'b0;
          end else if (req_i.block_length == '0) begin
            ctx_o = '{state: udfu_pkg::ST_MAN_SYNC, status: udfu_pkg::SC_OK};
          end else begin
            ctx_o = '{state: udfu_pkg::ST_DN_SYNC, status: udfu_pkg::SC_OK};
          end
        end
      end
      udfu_pkg::OP_GETSTATUS: begin
        tmo = poll_timeout_i;
        unique case (ctx_i.state) inside
          udfu_pkg::ST_DN_SYNC, udfu_pkg::ST_DN_BUSY: begin
            ctx_o.state = req_i.flash_busy ? udfu_pkg::ST_DN_BUSY : udfu_pkg::ST_DN_IDLE;
          end
          udfu_pkg::ST_MAN_SYNC: ctx_o.state = udfu_pkg::ST_MAN;
          udfu_pkg::ST_MAN:      ctx_o.state = udfu_pkg::ST_IDLE;
          default: ;
        endcase
      end
      udfu_pkg::OP_CLRSTATUS: begin
        if (ctx_i.state == udfu_pkg::ST_ERROR) begin
          ctx_o = '{state: udfu_pkg::ST_IDLE, status: udfu_pkg::SC_OK};
        end else begin
          ctx_o = '{state: udfu_pkg::ST_ERROR, status: udfu_pkg::SC_STALLED};
          ok    = 1'b0;
        end
      end
      default: begin
        ctx_o = '{state: udfu_pkg::ST_IDLE, status: udfu_pkg::SC_OK};
      end
    endcase
  end

  assign rsp_o = '{accepted:         ok,
                   status_code:      ctx_o.status,
                   state_code:       ctx_o.state,
                   reported_timeout: tmo};

endmodule

FILE: rtl/core/usb_dfu_download_state_machine.sv
// Channel   Modport  Contents
// req_i     sink     op, block_length, packet_offset, packet_length, flash_busy
// rsp_o     source   accepted, status_code, state_code, reported_timeout
// cfg_i     sink     poll timeout write data, always ready
//
// A request passes through the input register and then the result register.
// Its result is presented once the evaluation stage has fired, and can be
// transferred out when rsp_o.ready is high.
// A new request is taken every cycle while rsp_o does not stall, since the
// evaluation stage updates the state in one pass.
// Reset clears the protocol state to idle with status ok and the poll timeout to 1.
// A stall on rsp_o holds the result; the input register keeps accepting until it is full.
module usb_dfu_download_state_machine (
  input  logic           clk_i,
  input  logic           rst_ni,
  udfu_req_if.sink       req_i,
  udfu_rsp_if.source     rsp_o,
  udfu_cfg_if.sink       cfg_i
);

  // Input register stage.
  logic            req_valid_q, req_valid_d;
  udfu_pkg::req_t  req_q;

  // Result register stage.
  logic            rsp_valid_q, rsp_valid_d;
  udfu_pkg::rsp_t  rsp_q, rsp_d;

  // Protocol context and the poll timeout register.
  udfu_pkg::ctx_t  ctx_q, ctx_d;
  logic [23:0]     poll_timeout_q;

  logic            rsp_free;
  logic            eval_fire;
  logic            req_fire;

  // The result register can take a new value when it is empty or being drained.
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign eval_fire   = req_valid_q && rsp_free;
  assign req_i.ready = !req_valid_q || rsp_free;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    req_valid_d = req_valid_q;
    if (req_fire) begin
      req_valid_d = 1'b1;
    end else if (eval_fire) begin
      req_valid_d = 1'b0;
    end
    rsp_valid_d = rsp_valid_q;
    if (eval_fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  // The whole request is evaluated against the current context in one pass.
  udfu_step u_step (
    .ctx_i          (ctx_q),
    .req_i          (req_q),
    .poll_timeout_i (poll_timeout_q),
    .ctx_o          (ctx_d),
    .rsp_o          (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q    <= 1'b0;
      rsp_valid_q    <= 1'b0;
      ctx_q          <= '{state: udfu_pkg::ST_IDLE, status: udfu_pkg::SC_OK};
      poll_timeout_q <= udfu_pkg::POLL_TIMEOUT_RESET;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
      if (eval_fire) begin
        ctx_q <= ctx_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        poll_timeout_q <= cfg_i.data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= '{op:            req_i.op,
                 block_length:  req_i.block_length,
                 packet_offset: req_i.packet_offset,
                 packet_length: req_i.packet_length,
                 flash_busy:    req_i.flash_busy};
    end
    if (eval_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.accepted         = rsp_q.accepted;
  assign rsp_o.status_code      = rsp_q.status_code;
  assign rsp_o.state_code       = rsp_q.state_code;
  assign rsp_o.reported_timeout = rsp_q.reported_timeout;

  // The reported state and status match the context left behind by the request.
  a_ctx_matches_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_fire |=> (ctx_q.state == rsp_q.state_code && ctx_q.status == rsp_q.status_code))
    else $error("context differs from the reported result");

  // Every stalled request leaves the machine in the error state.
  a_stall_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_q.accepted) |-> (rsp_q.state_code == udfu_pkg::ST_ERROR))
    else $error("stalled request outside the error state");

  // A status other than ok is only held in the error state.
  a_status_needs_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctx_q.status != udfu_pkg::SC_OK) |-> (ctx_q.state == udfu_pkg::ST_ERROR))
    else $error("error status outside the error state");

  // A nonzero timeout comes only from a status reply, which is never stalled.
  a_timeout_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.reported_timeout != '0) |-> rsp_q.accepted)
    else $error("timeout reported on a stalled request");

endmodule
